### rtl/core/vrsl_pkg.sv
package vrsl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int STEP_LIMIT  = 3;

    localparam int UV_W     = 22;
    localparam int TUV_W    = 21;
    localparam int DUTY_W   = 7;
    localparam int IDX_W    = 7;
    localparam int PER_W    = 20;
    localparam int VSTEP_W  = 14;
    localparam int PROD_W   = IDX_W + VSTEP_W;
    localparam int ENT_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 21;

    localparam logic [CFG_AW-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TBL_ENTRIES = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PWM_PERIOD  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_VREG_MIN    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_VREG_STEP   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_VREG_NUM    = 3'd5;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic MODE_TABLE  = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    // operation handed to the shared add/subtract unit
    typedef struct packed {
        logic            sub;
        logic [UV_W-1:0] a;
        logic [UV_W-1:0] b;
    } vrsl_op_t;

    // flag is the carry out of an add, the borrow of a subtract
    typedef struct packed {
        logic [UV_W-1:0] value;
        logic            flag;
    } vrsl_res_t;

endpackage

### rtl/core/vrsl_addsub.sv
module vrsl_addsub (
    input  vrsl_pkg::vrsl_op_t  op,
    output vrsl_pkg::vrsl_res_t res
);
    import vrsl_pkg::*;

    logic [UV_W:0] sum;

    always_comb begin
        if (op.sub) begin
            sum = {1'b0, op.a} - {1'b0, op.b};
        end else begin
            sum = {1'b0, op.a} + {1'b0, op.b};
        end
        res.value = sum[UV_W-1:0];
        res.flag  = sum[UV_W];
    end

endmodule

### rtl/core/voltage_ramp_step_limiter.sv
// Voltage slew limiter for one supply domain.
// Input channel (s_*): a load beat writes one table slot and gives no result;
// a request beat moves the applied step toward the target, at most three
// positions per result, and gives one result beat per applied step (m_*),
// with m_last set on the final one. An unreachable request gives one beat
// with m_status set and every other field zero but m_last.
// Configuration (cfg_*): one register per beat, always ready; write only
// while no request is in flight.
// Table mode searches the entries in order, up to table_entries (at most
// TABLE_DEPTH); linear mode runs a range check, then restoring division
// unless the step size is zero. Each result then goes through step and
// multiply, then form and register. One add/subtract unit does table and
// range compares, range sums and division steps, so one request is handled
// at a time. s_ready is high only between requests; a last result may still
// wait in the output register while the next item is accepted.
// When the receiver stalls, the sequencer holds before loading the next
// result. Reset clears the applied step, the output valid flag and the
// configuration registers; table contents are undefined until loaded.
module voltage_ramp_step_limiter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [vrsl_pkg::SLOT_W-1:0]   s_entry_slot,
    input  logic [vrsl_pkg::TUV_W-1:0]    s_entry_uv,
    input  logic [vrsl_pkg::DUTY_W-1:0]   s_entry_duty,
    input  logic [vrsl_pkg::UV_W-1:0]     s_request_uv,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [vrsl_pkg::IDX_W-1:0]    m_step_index,
    output logic [vrsl_pkg::DUTY_W-1:0]   m_duty_pct,
    output logic [vrsl_pkg::PER_W-1:0]    m_period_out_ns,
    output logic [vrsl_pkg::UV_W-1:0]     m_actual_uv,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vrsl_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [vrsl_pkg::CFG_DW-1:0]   cfg_data
);
    import vrsl_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_LMUL   = 4'd2;
    localparam logic [3:0] ST_LMIN   = 4'd3;
    localparam logic [3:0] ST_LTOP   = 4'd4;
    localparam logic [3:0] ST_LCHK   = 4'd5;
    localparam logic [3:0] ST_LDIV   = 4'd6;
    localparam logic [3:0] ST_PREP   = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W:0] LIMIT_W = (IDX_W + 1)'(STEP_LIMIT);

    // configuration
    logic               mode_reg;
    logic [ENT_W-1:0]   tbl_entries_reg;
    logic [PER_W-1:0]   pwm_period_reg;
    logic [TUV_W-1:0]   vreg_min_reg;
    logic [VSTEP_W-1:0] vreg_step_reg;
    logic [IDX_W-1:0]   vreg_num_reg;

    // table store, no reset
    logic [TUV_W-1:0]   tbl_uv_mem   [TABLE_DEPTH];
    logic [DUTY_W-1:0]  tbl_duty_mem [TABLE_DEPTH];

    // sequencer state
    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               step_valid_reg, step_valid_next;
    logic [UV_W-1:0]    req_reg, req_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic [IDX_W-1:0]   srch_reg, srch_next;
    logic [2:0]         bit_reg, bit_next;
    logic [UV_W-1:0]    rem_reg, rem_next;
    logic [UV_W-1:0]    top_reg, top_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               err_reg, err_next;
    logic               last_reg, last_next;
    logic               inrange_reg, inrange_next;
    logic [TUV_W-1:0]   uv_rd_reg, uv_rd_next;
    logic [DUTY_W-1:0]  duty_rd_reg, duty_rd_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_status_reg, m_status_next;
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;
    logic [DUTY_W-1:0]  m_duty_reg, m_duty_next;
    logic [PER_W-1:0]   m_period_reg, m_period_next;
    logic [UV_W-1:0]    m_uv_reg, m_uv_next;
    logic               m_last_reg, m_last_next;

    vrsl_op_t           alu_op;
    vrsl_res_t          alu_res;
    logic [IDX_W-1:0]   num_entries;
    logic [IDX_W-1:0]   nxt;
    logic [IDX_W:0]     cur_w, tgt_w;
    logic [TBL_AW-1:0]  rd_addr;
    logic [IDX_W-1:0]   mul_a;
    logic               slot_ok;
    logic               in_acc;

    vrsl_addsub u_addsub (
        .op  (alu_op),
        .res (alu_res)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_step_index    = m_idx_reg;
    assign m_duty_pct      = m_duty_reg;
    assign m_period_out_ns = m_period_reg;
    assign m_actual_uv     = m_uv_reg;
    assign m_last          = m_last_reg;

    always_comb begin
        if ({2'b00, tbl_entries_reg} > DEPTH_W) begin
            num_entries = DEPTH_W[IDX_W-1:0];
        end else begin
            num_entries = {2'b00, tbl_entries_reg};
        end
    end

    // next applied step: jump on the first request, else move at most the limit
    always_comb begin
        cur_w = {1'b0, cur_reg};
        tgt_w = {1'b0, target_reg};
        if (!step_valid_reg) begin
            nxt = target_reg;
        end else if (cur_w < tgt_w) begin
            nxt = (cur_w + LIMIT_W < tgt_w) ? IDX_W'(cur_w + LIMIT_W) : target_reg;
        end else begin
            nxt = (cur_w > tgt_w + LIMIT_W) ? IDX_W'(cur_w - LIMIT_W) : target_reg;
        end
    end

    assign rd_addr = (state_reg == ST_SEARCH) ? srch_reg[TBL_AW-1:0] : nxt[TBL_AW-1:0];
    assign mul_a   = (state_reg == ST_PREP) ? nxt : vreg_num_reg;
    assign slot_ok = ({{(IDX_W + 1 - SLOT_W){1'b0}}, s_entry_slot} < DEPTH_W);

    // operand select for the shared unit
    always_comb begin
        alu_op.sub = 1'b1;
        alu_op.a   = req_reg;
        alu_op.b   = '0;
        case (state_reg)
            ST_SEARCH: begin
                alu_op.b = {1'b0, tbl_uv_mem[rd_addr]};
            end
            ST_LMIN: begin
                alu_op.b = {1'b0, vreg_min_reg};
            end
            ST_LTOP, ST_EMIT: begin
                alu_op.sub = 1'b0;
                alu_op.a   = {1'b0, vreg_min_reg};
                alu_op.b   = {1'b0, prod_reg};
            end
            ST_LCHK: begin
                alu_op.a = top_reg;
                alu_op.b = req_reg;
            end
            ST_LDIV: begin
                alu_op.a = rem_reg;
                alu_op.b = {{(UV_W - VSTEP_W){1'b0}}, vreg_step_reg} << bit_reg;
            end
            default: begin
                alu_op.sub = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        step_valid_next = step_valid_reg;
        req_next        = req_reg;
        target_next     = target_reg;
        srch_next       = srch_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        top_next        = top_reg;
        prod_next       = prod_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        inrange_next    = inrange_reg;
        uv_rd_next      = uv_rd_reg;
        duty_rd_next    = duty_rd_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_duty_next     = m_duty_reg;
        m_period_next   = m_period_reg;
        m_uv_next       = m_uv_reg;
        m_last_next     = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_cmd == CMD_REQUEST) begin
                    req_next = s_request_uv;
                    err_next = 1'b0;
                    if (mode_reg == MODE_LINEAR) begin
                        state_next = ST_LMUL;
                    end else if (num_entries == '0) begin
                        err_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        srch_next  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (!alu_res.flag) begin
                    target_next = srch_reg;
                    state_next  = ST_PREP;
                end else if (srch_reg == num_entries - 1'b1) begin
                    err_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    srch_next = srch_reg + 1'b1;
                end
            end
            ST_LMUL: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(vreg_step_reg);
                state_next = ST_LMIN;
            end
            ST_LMIN: begin
                rem_next = alu_res.value;
                if (alu_res.flag) begin
                    err_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_LTOP;
                end
            end
            ST_LTOP: begin
                top_next   = alu_res.value;
                state_next = ST_LCHK;
            end
            ST_LCHK: begin
                target_next = '0;
                bit_next    = 3'(IDX_W - 1);
                if (alu_res.flag) begin
                    err_next   = 1'b1;
                    state_next = ST_EMIT;
                end else if (vreg_step_reg == '0) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_LDIV;
                end
            end
            ST_LDIV: begin
                if (!alu_res.flag) begin
                    rem_next             = alu_res.value;
                    target_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = ST_PREP;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_PREP: begin
                cur_next        = nxt;
                step_valid_next = 1'b1;
                last_next       = (nxt == target_reg);
                prod_next       = PROD_W'(mul_a) * PROD_W'(vreg_step_reg);
                inrange_next    = ({1'b0, nxt} < DEPTH_W);
                uv_rd_next      = tbl_uv_mem[rd_addr];
                duty_rd_next    = tbl_duty_mem[rd_addr];
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_status_next = 1'b1;
                        m_idx_next    = '0;
                        m_duty_next   = '0;
                        m_period_next = '0;
                        m_uv_next     = '0;
                        m_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        m_status_next = 1'b0;
                        m_idx_next    = cur_reg;
                        m_last_next   = last_reg;
                        if (mode_reg == MODE_LINEAR) begin
                            m_duty_next   = '0;
                            m_period_next = '0;
                            m_uv_next     = alu_res.value;
                        end else begin
                            m_period_next = pwm_period_reg;
                            m_duty_next   = inrange_reg ? duty_rd_reg : '0;
                            m_uv_next     = inrange_reg ? {1'b0, uv_rd_reg} : '0;
                        end
                        state_next = last_reg ? ST_IDLE : ST_PREP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            step_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            step_valid_reg <= step_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        target_reg   <= target_next;
        srch_reg     <= srch_next;
        bit_reg      <= bit_next;
        rem_reg      <= rem_next;
        top_reg      <= top_next;
        prod_reg     <= prod_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
        inrange_reg  <= inrange_next;
        uv_rd_reg    <= uv_rd_next;
        duty_rd_reg  <= duty_rd_next;
        m_status_reg <= m_status_next;
        m_idx_reg    <= m_idx_next;
        m_duty_reg   <= m_duty_next;
        m_period_reg <= m_period_next;
        m_uv_reg     <= m_uv_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_cmd == CMD_LOAD && slot_ok) begin
            tbl_uv_mem[s_entry_slot[TBL_AW-1:0]]   <= s_entry_uv;
            tbl_duty_mem[s_entry_slot[TBL_AW-1:0]] <= s_entry_duty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_TABLE;
            tbl_entries_reg <= ENT_W'(1);
            pwm_period_reg  <= '0;
            vreg_min_reg    <= '0;
            vreg_step_reg   <= VSTEP_W'(1);
            vreg_num_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[0];
                REG_TBL_ENTRIES: tbl_entries_reg <= cfg_data[ENT_W-1:0];
                REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data[PER_W-1:0];
                REG_VREG_MIN:    vreg_min_reg    <= cfg_data[TUV_W-1:0];
                REG_VREG_STEP:   vreg_step_reg   <= cfg_data[VSTEP_W-1:0];
                REG_VREG_NUM:    vreg_num_reg    <= cfg_data[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid not cleared by reset");

    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last && m_step_index == '0 && m_actual_uv == '0))
        else $error("error beat carries a step");

    a_step_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_PREP) |=> $stable(cur_reg))
        else $error("applied step changed outside step update");

    a_step_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP && step_valid_reg) |=>
        (({1'b0, cur_reg} <= {1'b0, $past(cur_reg)} + LIMIT_W) &&
         ({1'b0, cur_reg} + LIMIT_W >= {1'b0, $past(cur_reg)})))
        else $error("applied step moved beyond the slew limit");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vrsl_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [TUV_W-1:0]  uv;
        logic [DUTY_W-1:0] duty;
        logic [UV_W-1:0]   req;
    } ramp_item_t;

    typedef struct packed {
        logic              status;
        logic [IDX_W-1:0]  idx;
        logic [DUTY_W-1:0] duty;
        logic [PER_W-1:0]  period;
        logic [UV_W-1:0]   uv;
        logic              last;
    } ramp_beat_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CFG_AW-1:0] reg_idx;
        int unsigned       reg_val;
        ramp_item_t        item;
        bit                typed;
        ramp_beat_t        want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_cmd = CMD_LOAD;
    logic [SLOT_W-1:0]   s_entry_slot = '0;
    logic [TUV_W-1:0]    s_entry_uv = '0;
    logic [DUTY_W-1:0]   s_entry_duty = '0;
    logic [UV_W-1:0]     s_request_uv = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic [IDX_W-1:0]    m_step_index;
    logic [DUTY_W-1:0]   m_duty_pct;
    logic [PER_W-1:0]    m_period_out_ns;
    logic [UV_W-1:0]     m_actual_uv;
    logic                m_last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;

    // shadow of the block: registers, table and applied step
    int unsigned         sh_mode = MODE_TABLE;
    int unsigned         sh_entries = 1;
    int unsigned         sh_pwm = 0;
    int unsigned         sh_min = 0;
    int unsigned         sh_step = 1;
    int unsigned         sh_num = 0;
    logic [TUV_W-1:0]    tbl_uv [TABLE_DEPTH];
    logic [DUTY_W-1:0]   tbl_duty [TABLE_DEPTH];
    int unsigned         cur_step = 0;
    bit                  have_step = 1'b0;

    ramp_beat_t          ramp_beats[$];
    ramp_beat_t          pending_beats[$];
    stim_row_t           directed_rows[$];
    int                  mismatch_count = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    bit                  hold_request = 1'b0;
    int unsigned         hold_left = 0;

    voltage_ramp_step_limiter u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_entry_slot    (s_entry_slot),
        .s_entry_uv      (s_entry_uv),
        .s_entry_duty    (s_entry_duty),
        .s_request_uv    (s_request_uv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_step_index    (m_step_index),
        .m_duty_pct      (m_duty_pct),
        .m_period_out_ns (m_period_out_ns),
        .m_actual_uv     (m_actual_uv),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    initial begin
        #(4_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic ramp_beat_t mk_beat(input bit st, input int unsigned idx,
                                           input int unsigned duty, input int unsigned per,
                                           input int unsigned uv, input bit last);
        ramp_beat_t b;
        b.status = st;
        b.idx    = idx[IDX_W-1:0];
        b.duty   = duty[DUTY_W-1:0];
        b.period = per[PER_W-1:0];
        b.uv     = uv[UV_W-1:0];
        b.last   = last;
        return b;
    endfunction

    function automatic ramp_item_t mk_load(input int unsigned slot, input int unsigned uv,
                                           input int unsigned duty);
        ramp_item_t it;
        it.cmd  = CMD_LOAD;
        it.slot = slot[SLOT_W-1:0];
        it.uv   = uv[TUV_W-1:0];
        it.duty = duty[DUTY_W-1:0];
        it.req  = $urandom_range(22'h3FFFFF);
        return it;
    endfunction

    function automatic ramp_item_t mk_req(input int unsigned req);
        ramp_item_t it;
        it.cmd  = CMD_REQUEST;
        it.slot = $urandom_range(15);
        it.uv   = $urandom_range(21'h1FFFFF);
        it.duty = $urandom_range(100);
        it.req  = req[UV_W-1:0];
        return it;
    endfunction

    function automatic void add_cfg(input logic [CFG_AW-1:0] idx, input int unsigned val);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input ramp_item_t it, input bit typed,
                                     input ramp_beat_t want);
        stim_row_t row;
        row.kind    = ROW_ITEM;
        row.reg_idx = '0;
        row.reg_val = 0;
        row.item    = it;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endfunction

    function automatic ramp_beat_t applied_beat(input int unsigned idx, input bit last);
        int unsigned duty;
        int unsigned per;
        int unsigned uv;
        duty = 0;
        per  = 0;
        uv   = 0;
        if (sh_mode == MODE_TABLE) begin
            per = sh_pwm;
            // steps left over from linear mode may lie past the table
            if (idx < TABLE_DEPTH) begin
                duty = tbl_duty[idx];
                uv   = tbl_uv[idx];
            end
        end else begin
            uv = sh_min + idx * sh_step;
        end
        return mk_beat(1'b0, idx, duty, per, uv, last);
    endfunction

    // Work out the result beats of one accepted item into ramp_beats.
    function automatic void predict_ramp(input ramp_item_t it);
        int unsigned req;
        int unsigned target;
        int unsigned n;
        int unsigned top;
        int unsigned c;
        int unsigned i;
        bit          found;
        ramp_beats.delete();
        if (it.cmd == CMD_LOAD) begin
            tbl_uv[it.slot]   = it.uv;
            tbl_duty[it.slot] = it.duty;
            return;
        end
        req    = it.req;
        target = 0;
        found  = 1'b0;
        if (sh_mode == MODE_TABLE) begin
            n = (sh_entries > TABLE_DEPTH) ? TABLE_DEPTH : sh_entries;
            for (i = 0; i < n && !found; i++) begin
                if (tbl_uv[i] <= req) begin
                    target = i;
                    found  = 1'b1;
                end
            end
        end else begin
            top = sh_min + sh_num * sh_step;
            if (req >= sh_min && req <= top) begin
                target = (sh_step != 0) ? (req - sh_min) / sh_step : 0;
                found  = 1'b1;
            end
        end
        if (!found) begin
            ramp_beats.push_back(mk_beat(1'b1, 0, 0, 0, 0, 1'b1));
            return;
        end
        // jump on the first request and report in place when already there
        if (!have_step || cur_step == target) begin
            cur_step  = target;
            have_step = 1'b1;
            ramp_beats.push_back(applied_beat(target, 1'b1));
            return;
        end
        c = cur_step;
        while (c != target) begin
            if (c < target)
                c = (c + STEP_LIMIT < target) ? c + STEP_LIMIT : target;
            else
                c = (c > target + STEP_LIMIT) ? c - STEP_LIMIT : target;
            ramp_beats.push_back(applied_beat(c, c == target));
        end
        cur_step = c;
    endfunction

    function automatic ramp_item_t rand_request();
        int unsigned req;
        int unsigned j;
        int unsigned k;
        k = $urandom_range(15);
        if ($urandom_range(9) < 2) begin
            req = $urandom_range(22'h3FFFFF);
        end else if (sh_mode == MODE_TABLE) begin
            req = tbl_uv[k] + ($urandom_range(1) ? $urandom_range(60000) : 0);
        end else if ($urandom_range(5) == 0) begin
            // just outside the linear range on either side
            req = $urandom_range(1) ? sh_min - 1 : sh_min + sh_num * sh_step + 1;
        end else begin
            j   = $urandom_range(sh_num);
            req = sh_min + j * sh_step;
            if (j < sh_num && sh_step > 0)
                req = req + $urandom_range(sh_step - 1);
        end
        return mk_req(req & 32'h3FFFFF);
    endfunction

    task automatic set_idling(input int unsigned snd, input int unsigned rcv, input bit hold);
        @(posedge aclk);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        hold_request   = hold;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge aclk);
        // loads give no beat, so give the block time to finish one
        repeat (40) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_MODE:        sh_mode    = val & 32'h1;
            REG_TBL_ENTRIES: sh_entries = val & 32'h1F;
            REG_PWM_PERIOD:  sh_pwm     = val & 32'hFFFFF;
            REG_VREG_MIN:    sh_min     = val & 32'h1FFFFF;
            REG_VREG_STEP:   sh_step    = val & 32'h3FFF;
            REG_VREG_NUM:    sh_num     = val & 32'h7F;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_item(input ramp_item_t it, input bit typed, input ramp_beat_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= it.cmd;
        s_entry_slot <= it.slot;
        s_entry_uv   <= it.uv;
        s_entry_duty <= it.duty;
        s_request_uv <= it.req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_ramp(it);
        if (typed)
            pending_beats.push_back(want);
        else
            foreach (ramp_beats[k])
                pending_beats.push_back(ramp_beats[k]);
        @(negedge aclk);
    endtask

    task automatic write_settings(input int ph);
        int unsigned md;
        int unsigned ent;
        int unsigned per;
        int unsigned vmin;
        int unsigned vstep;
        int unsigned vnum;
        if (ph == 0) begin
            md = MODE_TABLE; ent = 1; per = 0; vmin = 0; vstep = 1; vnum = 0;
        end else if (ph == 1) begin
            md = MODE_LINEAR; ent = 31; per = 20'hFFFFF; vmin = 21'h1FFFFF;
            vstep = 16383; vnum = 127;
        end else begin
            md = $urandom_range(1);
            case ($urandom_range(7))
                0:       ent = 0;
                1:       ent = $urandom_range(31, 17);
                default: ent = $urandom_range(16, 1);
            endcase
            case ($urandom_range(3))
                0:       per = 0;
                1:       per = 20'hFFFFF;
                default: per = $urandom_range(20'hFFFFF);
            endcase
            case ($urandom_range(7))
                0, 1:    vmin = 0;
                2:       vmin = 21'h1FFFFF;
                default: vmin = $urandom_range(1_000_000);
            endcase
            case ($urandom_range(15))
                0, 1:    vstep = 1;
                2, 3:    vstep = 16383;
                4:       vstep = 0;
                default: vstep = $urandom_range(16383, 1);
            endcase
            case ($urandom_range(7))
                0:       vnum = 0;
                1:       vnum = 127;
                default: vnum = $urandom_range(127);
            endcase
        end
        cfg_write(REG_MODE, md);
        cfg_write(REG_TBL_ENTRIES, ent);
        cfg_write(REG_PWM_PERIOD, per);
        cfg_write(REG_VREG_MIN, vmin);
        cfg_write(REG_VREG_STEP, vstep);
        cfg_write(REG_VREG_NUM, vnum);
    endtask

    // Load all slots with a descending table of random content.
    task automatic reload_table();
        int unsigned v;
        int unsigned dec;
        int          i;
        v = $urandom_range(21'h1FFFFF);
        for (i = 0; i < TABLE_DEPTH; i++) begin
            send_item(mk_load(i, v, $urandom_range(100)), 1'b0, '0);
            dec = $urandom_range(200000);
            v   = (dec > v) ? 0 : v - dec;
            if (i == TABLE_DEPTH - 2 && $urandom_range(1))
                v = 0;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        ramp_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with no expected beat pending");
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("status", want.status, m_status);
                check_field("step_index", want.idx, m_step_index);
                check_field("duty_pct", want.duty, m_duty_pct);
                check_field("period_out_ns", want.period, m_period_out_ns);
                check_field("actual_uv", want.uv, m_actual_uv);
                check_field("last", want.last, m_last);
            end
        end
    end

    initial begin : stimulus
        stim_row_t  row;
        ramp_beat_t err;
        int         i;
        int         ph;

        err = mk_beat(1'b1, 0, 0, 0, 0, 1'b1);
        for (i = 0; i < TABLE_DEPTH; i++)
            add_item(mk_load(i, (i == 0) ? 21'h1FFFFF : (15 - i) * 100000,
                             (i == 0) ? 100 : (15 - i) * 6), 1'b0, '0);
        add_cfg(REG_TBL_ENTRIES, 16);
        add_cfg(REG_PWM_PERIOD, 20'hFFFFF);
        add_item(mk_req(22'h3FFFFF), 1'b1, mk_beat(1'b0, 0, 100, 20'hFFFFF, 21'h1FFFFF, 1'b1));
        add_item(mk_req(0), 1'b0, '0);
        add_item(mk_req(0), 1'b1, mk_beat(1'b0, 15, 0, 20'hFFFFF, 0, 1'b1));
        add_cfg(REG_TBL_ENTRIES, 0);
        add_item(mk_req(12345), 1'b1, err);
        add_cfg(REG_TBL_ENTRIES, 31);
        add_item(mk_req(0), 1'b1, mk_beat(1'b0, 15, 0, 20'hFFFFF, 0, 1'b1));
        add_cfg(REG_TBL_ENTRIES, 2);
        add_item(mk_req(1399999), 1'b1, err);
        add_cfg(REG_MODE, MODE_LINEAR);
        add_cfg(REG_VREG_MIN, 1000);
        add_cfg(REG_VREG_STEP, 100);
        add_cfg(REG_VREG_NUM, 127);
        add_item(mk_req(999), 1'b1, err);
        add_item(mk_req(13700), 1'b0, '0);
        add_item(mk_req(13701), 1'b1, err);
        add_item(mk_req(1050), 1'b0, '0);
        add_cfg(REG_VREG_STEP, 0);
        add_item(mk_req(1000), 1'b1, mk_beat(1'b0, 0, 0, 0, 1000, 1'b1));
        add_item(mk_req(1001), 1'b1, err);
        add_cfg(REG_VREG_MIN, 21'h1FFFFF);
        add_cfg(REG_VREG_STEP, 16383);
        add_item(mk_req(22'h3FFFFF), 1'b1, err);
        add_item(mk_req(4177792), 1'b0, '0);
        add_cfg(REG_MODE, MODE_TABLE);
        add_item(mk_req(22'h3FFFFF), 1'b0, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(0, 0, 1'b0);
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.item, row.typed, row.want);
            end
        end

        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0:       set_idling(0, 0, 1'b0);
                1:       set_idling(46, 0, 1'b0);
                2:       set_idling(0, 46, ph == 2);
                default: set_idling(31, 31, 1'b0);
            endcase
            write_settings(ph);
            if (ph == 0 || ph == 4)
                reload_table();
            repeat (6) begin
                if ($urandom_range(4) == 0)
                    send_item(mk_load($urandom_range(15), $urandom_range(21'h1FFFFF),
                                      $urandom_range(100)), 1'b0, '0);
                else
                    send_item(rand_request(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/core/vrsl_pkg.sv
rtl/core/vrsl_addsub.sv
rtl/core/voltage_ramp_step_limiter.sv
test/testbench.sv
